@@ src/mfb_pkg.sv @@
// Shared types, widths and constants of the 3x3 mean filter.
package mfb_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 12;
	localparam int COL_OUT_W     = 10;
	localparam int CFG_W_W       = 11;
	localparam int CFG_DATA_W    = 12;
	localparam int CFG_IDX_W     = 1;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam int RESET_FRAME_WIDTH  = 1024;
	localparam int RESET_FRAME_HEIGHT = 768;

	localparam int WIN_N  = 9;
	localparam int KIND_N = 4;
	localparam int QDEPTH = 4;

	// Window sums reach 9 * 255; reciprocals are exact for any 12-bit sum.
	localparam int SUM_W       = 12;
	localparam int RECIP_W     = 14;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_9     = 7282;
	localparam int RECIP_6     = 10923;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_9 = 2'd0,
		DIV_6 = 2'd1,
		DIV_4 = 2'd2
	} div_kind_t;

	// Result kinds of one pixel, in the order they leave.
	typedef enum logic [1:0] {
		RES_UPPER     = 2'd0,
		RES_LOWER     = 2'd1,
		RES_UPPER_END = 2'd2,
		RES_LOWER_END = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic [WIN_N-1:0][PIX_W-1:0] win;
		logic [ROW_W-1:0]            row;
		logic [COL_OUT_W-1:0]        col;
		logic [KIND_N-1:0]           mask;
		logic                        top_clip;
		logic                        left_clip;
	} job_t;

endpackage

@@ src/mfb_front.sv @@
// Front end: pixel intake, position tracking, line stores, window and job classification.
module mfb_front #(
	parameter int MAX_WIDTH = mfb_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mfb_pkg::PIX_W-1:0]       pixel_in,
	input  logic                            cfg_write,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            push,
	output mfb_pkg::job_t                   push_job,
	input  logic                            q_full
);

	localparam int PW      = mfb_pkg::PIX_W;
	localparam int RW      = mfb_pkg::ROW_W;
	localparam int OW      = mfb_pkg::COL_OUT_W;
	localparam int CW      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW      = (CW > OW) ? CW : OW;
	localparam int KN      = mfb_pkg::KIND_N;
	localparam int RESET_W = (mfb_pkg::RESET_FRAME_WIDTH < MAX_WIDTH) ?
		mfb_pkg::RESET_FRAME_WIDTH : MAX_WIDTH;
	localparam logic [CW-1:0] RESET_LAST_COL = CW'(RESET_W - 1);
	localparam logic [RW-1:0] RESET_LAST_ROW = RW'(mfb_pkg::RESET_FRAME_HEIGHT - 1);

	logic [CW-1:0] last_col_q, in_col_q;
	logic [RW-1:0] last_row_q, in_row_q;
	logic [mfb_pkg::CFG_W_W-1:0] cfg_w;
	logic [RW-1:0] cfg_h;
	logic [CW-1:0] new_last_col;
	logic [RW-1:0] new_last_row;

	logic accept, s1_adv;
	logic is_last_row, is_end_col, row_ge1, col_ge1;
	logic [KN-1:0] mask_now;
	logic [XW-1:0] col_x;

	logic                  valid_s1;
	logic [PW-1:0]         pix_s1, up2_s1, up1_s1;
	logic [CW-1:0]         c_s1;
	logic [RW-1:0]         row_s1;
	logic [OW-1:0]         col_s1;
	logic [KN-1:0]         mask_s1;
	logic                  top_clip_s1, left_clip_s1;

	logic [mfb_pkg::WIN_N-1:0][PW-1:0] window_q, win_next;

	logic [PW-1:0] line_store_older [MAX_WIDTH];
	logic [PW-1:0] line_store_newer [MAX_WIDTH];

	// Clamp register values to the frame sizes the datapath supports.
	always_comb begin
		cfg_w = cfg_data[mfb_pkg::CFG_W_W-1:0];
		cfg_h = cfg_data[RW-1:0];
		if (32'(cfg_w) < 32'd2) begin
			new_last_col = CW'(1);
		end else if (32'(cfg_w) >= 32'(MAX_WIDTH)) begin
			new_last_col = CW'(MAX_WIDTH - 1);
		end else begin
			new_last_col = CW'(32'(cfg_w) - 32'd1);
		end
		if (cfg_h < RW'(2)) begin
			new_last_row = RW'(1);
		end else begin
			new_last_row = cfg_h - RW'(1);
		end
	end

	always_comb begin
		is_last_row = (in_row_q == last_row_q);
		is_end_col  = (in_col_q == last_col_q);
		row_ge1     = (in_row_q != '0);
		col_ge1     = (in_col_q != '0);
		mask_now[mfb_pkg::RES_UPPER]     = row_ge1 & col_ge1;
		mask_now[mfb_pkg::RES_LOWER]     = row_ge1 & col_ge1 & is_last_row;
		mask_now[mfb_pkg::RES_UPPER_END] = row_ge1 & is_end_col;
		mask_now[mfb_pkg::RES_LOWER_END] = row_ge1 & is_end_col & is_last_row;
		col_x = XW'(in_col_q);
	end

	// Stage 1 moves on when it has no result to queue or the queue has room.
	assign s1_adv   = valid_s1 & ((mask_s1 == '0) | ~q_full);
	assign in_ready = ~valid_s1 | s1_adv;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RESET_LAST_COL;
			last_row_q <= RESET_LAST_ROW;
			in_col_q   <= '0;
			in_row_q   <= '0;
		end else if (cfg_write) begin
			unique case (mfb_pkg::cfg_reg_t'(cfg_index))
				mfb_pkg::REG_FRAME_WIDTH:  last_col_q <= new_last_col;
				mfb_pkg::REG_FRAME_HEIGHT: last_row_q <= new_last_row;
				default: ;
			endcase
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (accept) begin
			if (is_end_col) begin
				in_col_q <= '0;
				in_row_q <= is_last_row ? '0 : in_row_q + RW'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel_in;
			c_s1         <= in_col_q;
			row_s1       <= in_row_q;
			col_s1       <= col_x[OW-1:0];
			mask_s1      <= mask_now;
			top_clip_s1  <= (in_row_q < RW'(2));
			left_clip_s1 <= (in_col_q < CW'(2)) | (CW == 1);
		end
	end

	// Line stores: read at intake, write back when the pixel leaves stage 1.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_store_older[c_s1] <= up1_s1;
		end
		if (accept) begin
			up2_s1 <= line_store_older[in_col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_store_newer[c_s1] <= pix_s1;
		end
		if (accept) begin
			up1_s1 <= line_store_newer[in_col_q];
		end
	end

	// Shift the window left and bring in the new column.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r*3]     = window_q[r*3 + 1];
			win_next[r*3 + 1] = window_q[r*3 + 2];
		end
		win_next[2] = up2_s1;
		win_next[5] = up1_s1;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q <= win_next;
		end
	end

	assign push = s1_adv & (mask_s1 != '0);

	always_comb begin
		push_job.win       = win_next;
		push_job.row       = row_s1;
		push_job.col       = col_s1;
		push_job.mask      = mask_s1;
		push_job.top_clip  = top_clip_s1;
		push_job.left_clip = left_clip_s1;
	end

endmodule

@@ src/mfb_queue.sv @@
// Small job queue between front and back.
module mfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mfb_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output mfb_pkg::job_t head_job
);

	localparam int D  = mfb_pkg::QDEPTH;
	localparam int PW = $clog2(D);
	localparam int NW = $clog2(D + 1);

	mfb_pkg::job_t   slot_q [D];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full       = (count_q == NW'(D));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ src/mfb_back.sv @@
// Back end: walks the results of each job, sums the window and divides.
module mfb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  mfb_pkg::job_t                   head_job,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mfb_pkg::ROW_W-1:0]       out_row,
	output logic [mfb_pkg::COL_OUT_W-1:0]   out_col,
	output logic [mfb_pkg::PIX_W-1:0]       mean_value,
	output logic                            frame_last
);

	localparam int RW  = mfb_pkg::ROW_W;
	localparam int OW  = mfb_pkg::COL_OUT_W;
	localparam int PW  = mfb_pkg::PIX_W;
	localparam int SW  = mfb_pkg::SUM_W;
	localparam int KN  = mfb_pkg::KIND_N;
	localparam int PRW = SW + mfb_pkg::RECIP_W;
	localparam int SH  = mfb_pkg::RECIP_SHIFT;

	logic [KN-1:0]       done_q, rem, pick;
	mfb_pkg::res_kind_t  kind;
	logic                last_pick, issue, s1_free, out_free;

	logic [RW-1:0]       row_sel;
	logic [OW-1:0]       col_sel;
	logic                top_off, left_off, last_sel;
	logic [SW-1:0]       sum;
	mfb_pkg::div_kind_t  div_sel;

	logic                valid_s1;
	logic [SW-1:0]       sum_s1;
	logic [RW-1:0]       row_s1;
	logic [OW-1:0]       col_s1;
	logic                last_s1;
	mfb_pkg::div_kind_t  div_s1;

	logic [mfb_pkg::RECIP_W-1:0] recip;
	logic [PRW-1:0]              prod;
	logic [PW-1:0]               mean;
	logic                        out_valid_q;

	// Pick the next outstanding result of the head job.
	always_comb begin
		rem = head_job.mask & ~done_q;
		priority if (rem[mfb_pkg::RES_UPPER]) begin
			kind = mfb_pkg::RES_UPPER;
		end else if (rem[mfb_pkg::RES_LOWER]) begin
			kind = mfb_pkg::RES_LOWER;
		end else if (rem[mfb_pkg::RES_UPPER_END]) begin
			kind = mfb_pkg::RES_UPPER_END;
		end else begin
			kind = mfb_pkg::RES_LOWER_END;
		end
		pick      = KN'(1) << kind;
		last_pick = ((rem & ~pick) == '0);
	end

	assign out_free = ~out_valid_q | out_ready;
	assign s1_free  = ~valid_s1 | out_free;
	assign issue    = head_valid & s1_free;
	assign pop      = issue & last_pick;

	always_comb begin
		unique case (kind)
			mfb_pkg::RES_UPPER: begin
				row_sel  = head_job.row - RW'(1);
				col_sel  = head_job.col - OW'(1);
				top_off  = head_job.top_clip;
				left_off = head_job.left_clip;
				last_sel = 1'b0;
			end
			mfb_pkg::RES_LOWER: begin
				row_sel  = head_job.row;
				col_sel  = head_job.col - OW'(1);
				top_off  = 1'b1;
				left_off = head_job.left_clip;
				last_sel = 1'b0;
			end
			mfb_pkg::RES_UPPER_END: begin
				row_sel  = head_job.row - RW'(1);
				col_sel  = head_job.col;
				top_off  = head_job.top_clip;
				left_off = 1'b1;
				last_sel = 1'b0;
			end
			mfb_pkg::RES_LOWER_END: begin
				row_sel  = head_job.row;
				col_sel  = head_job.col;
				top_off  = 1'b1;
				left_off = 1'b1;
				last_sel = 1'b1;
			end
			default: begin
				row_sel  = head_job.row;
				col_sel  = head_job.col;
				top_off  = 1'b1;
				left_off = 1'b1;
				last_sel = 1'b0;
			end
		endcase
	end

	// Sum the part of the window that lies inside the frame.
	always_comb begin
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 0 && top_off) && !(c == 0 && left_off)) begin
					sum = sum + SW'(head_job.win[r*3 + c]);
				end
			end
		end
		if (top_off && left_off) begin
			div_sel = mfb_pkg::DIV_4;
		end else if (top_off || left_off) begin
			div_sel = mfb_pkg::DIV_6;
		end else begin
			div_sel = mfb_pkg::DIV_9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				done_q <= last_pick ? '0 : (done_q | pick);
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s1 <= sum;
			row_s1 <= row_sel;
			col_s1 <= col_sel;
			last_s1 <= last_sel;
			div_s1 <= div_sel;
		end
	end

	// Divide by reciprocal multiply; by four is a shift.
	always_comb begin
		recip = (div_s1 == mfb_pkg::DIV_9) ? mfb_pkg::RECIP_W'(mfb_pkg::RECIP_9) :
			mfb_pkg::RECIP_W'(mfb_pkg::RECIP_6);
		prod = PRW'(sum_s1) * PRW'(recip);
		unique case (div_s1)
			mfb_pkg::DIV_4: mean = sum_s1[PW+1:2];
			mfb_pkg::DIV_6,
			mfb_pkg::DIV_9: mean = prod[SH+PW-1:SH];
			default:        mean = prod[SH+PW-1:SH];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_row    <= row_s1;
			out_col    <= col_s1;
			mean_value <= mean;
			frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/mean_filter_3x3_border.sv @@
// Top level of the streaming 3x3 mean filter with border handling.
//
//  Channel   Handshake               Payload                                  Dir
//  pixel     in_valid / in_ready     pixel_in                                 in
//  result    out_valid / out_ready   out_row, out_col, mean_value, frame_last out
//  config    cfg_write (no wait)     cfg_index, cfg_data                      in
//
// One pixel transaction can be taken every cycle while in_ready is high. Each pixel yields
// zero to four results, and the result register sends at most one per cycle, so the rate
// is set by the result count: one result per pixel inside the frame, two at a row end and
// per pixel on the last row, up to four at the last column of the last row.
// Reset clears counters, the window and the queue; line stores are not cleared.
// Either side may stall on its own: the job queue takes up to four pixels of slack.
module mean_filter_3x3_border #(
	parameter int MAX_WIDTH = mfb_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mfb_pkg::PIX_W-1:0]       pixel_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mfb_pkg::ROW_W-1:0]       out_row,
	output logic [mfb_pkg::COL_OUT_W-1:0]   out_col,
	output logic [mfb_pkg::PIX_W-1:0]       mean_value,
	output logic                            frame_last,
	input  logic                            cfg_write,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic          push, q_full, pop, head_valid;
	mfb_pkg::job_t push_job, head_job;

	// Front: take pixels, keep the line stores and window, drop pixels with no result.
	mfb_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	// Queue: hold window snapshots while the back end drains multi-result pixels.
	mfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: one result per cycle while a job waits and out_ready is high, through sum, divide and the output register.
	mfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_row    (out_row),
		.out_col    (out_col),
		.mean_value (mean_value),
		.frame_last (frame_last)
	);

	// The front must never queue a job into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	// The back end only retires a job that is present.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from empty queue");

	// The closing result of a frame is a bottom-right corner, never on row or column zero.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (out_row != '0 && out_col != '0))
		else $error("frame end flagged away from the corner");

endmodule
